[src/itcl_pkg.sv]
`default_nettype none
package itcl_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_BROKEN  = 2'd2;

  localparam logic [15:0] LEAF_MARK = 16'hFFFF;
  localparam int unsigned LEVELS = 4;

  typedef struct packed {
    logic        opcode;
    logic [15:0] word_address;
    logic [31:0] write_word;
    logic [31:0] ip_address;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] country_code;
  } rsp_word_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } walk_state_t;

endpackage
`default_nettype wire

[src/itcl_ram.sv]
`default_nettype none
module itcl_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/ipv4_trie_country_lookup.sv]
`default_nettype none
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_ready  table write or address lookup
// rsp       out        rsp_valid / rsp_ready  status and country code
//
// A write gives no result.
// A lookup reads the trie one level at a time through the single read port of the table
// memory, whose read data is registered; no new word is taken until the lookup ends.
// The result register is refilled only when it is empty or being taken; until then the
// last table read is repeated.
// Reset clears control state only; the table is undefined until written.
module ipv4_trie_country_lookup #(
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire itcl_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output itcl_pkg::rsp_word_t     rsp
);

  localparam int AW = $clog2(TABLE_WORDS);
  localparam logic [31:0] TableLimit = 32'(TABLE_WORDS);

  itcl_pkg::walk_state_t state, state_next;

  logic [1:0]    level;
  logic [31:0]   ip;
  logic [AW-1:0] rd_index;

  logic          req_fire;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_word;

  logic          out_free;
  logic          leaf;
  logic [7:0]    octet_next;
  logic [30:0]   next_index;
  logic          misaligned;
  logic          out_of_range;
  logic          finish;
  logic          advance;
  logic          load_rsp;
  itcl_pkg::rsp_word_t result;

  assign req_fire = req_valid && req_ready;
  assign wr_en    = req_fire && (req.opcode == itcl_pkg::OP_WRITE)
                    && ({16'd0, req.word_address} < TableLimit);
  assign out_free = !rsp_valid || rsp_ready;

  assign leaf       = (rd_word[31:16] == itcl_pkg::LEAF_MARK);
  assign misaligned = (rd_word[1:0] != 2'd0);

  always_comb begin
    case (level)
      2'd0:    octet_next = ip[23:16];
      2'd1:    octet_next = ip[15:8];
      default: octet_next = ip[7:0];
    endcase
  end

  assign next_index   = {1'b0, rd_word[31:2]} + {23'd0, octet_next};
  assign out_of_range = ({1'b0, next_index} >= TableLimit);
  assign finish       = leaf || (level == 2'(itcl_pkg::LEVELS - 1)) || misaligned
                        || out_of_range;

  always_comb begin
    result.status       = itcl_pkg::ST_BROKEN;
    result.country_code = 16'd0;
    if (leaf) begin
      if (rd_word[15:0] == 16'd0) begin
        result.status = itcl_pkg::ST_MISSING;
      end else begin
        result.status       = itcl_pkg::ST_FOUND;
        result.country_code = rd_word[15:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      itcl_pkg::S_IDLE: begin
        if (req_fire && req.opcode == itcl_pkg::OP_LOOKUP) begin
          state_next = itcl_pkg::S_WALK;
        end
      end
      itcl_pkg::S_WALK: begin
        if (finish && out_free) begin
          state_next = itcl_pkg::S_IDLE;
        end
      end
      default: state_next = itcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = rd_index;
    advance   = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      itcl_pkg::S_IDLE: begin
        req_ready = 1'b1;
        rd_en     = req_valid && (req.opcode == itcl_pkg::OP_LOOKUP);
        rd_addr   = AW'(req.ip_address[31:24]);
      end
      itcl_pkg::S_WALK: begin
        rd_en = 1'b1;
        if (finish) begin
          load_rsp = out_free;
        end else begin
          advance = 1'b1;
          rd_addr = next_index[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itcl_pkg::S_IDLE;
      rsp_valid <= 1'b0;
      level     <= 2'd0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_fire) begin
        level <= 2'd0;
      end else if (advance) begin
        level <= level + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      ip <= req.ip_address;
    end
    if (rd_en) begin
      rd_index <= rd_addr;
    end
    if (load_rsp) begin
      rsp <= result;
    end
  end

  itcl_ram #(
    .Width(32),
    .Depth(TABLE_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(req.word_address)),
    .wdata(req.write_word),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

endmodule
`default_nettype wire

[src/itcl_checker.sv]
`default_nettype none
module itcl_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire itcl_pkg::req_word_t req,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire itcl_pkg::rsp_word_t rsp
);

  // A result held back by the receiver stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == itcl_pkg::ST_FOUND || rsp.status == itcl_pkg::ST_MISSING
                  || rsp.status == itcl_pkg::ST_BROKEN)
    else $error("undefined status code");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != itcl_pkg::ST_FOUND |-> rsp.country_code == 16'd0)
    else $error("country code set without a match");

  a_code_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == itcl_pkg::ST_FOUND |-> rsp.country_code != 16'd0)
    else $error("match reported with an empty country code");

  // A lookup occupies the table read port, so no word is taken in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.opcode == itcl_pkg::OP_LOOKUP |=> !req_ready)
    else $error("word taken while a lookup walks the table");

endmodule

bind ipv4_trie_country_lookup itcl_checker u_itcl_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
`default_nettype wire

[verif/lookup_checker.sv]
module lookup_checker
  import itcl_pkg::*;
#(
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic       req_ready,
  input  wire req_word_t  req,
  input  wire logic       rsp_valid,
  input  wire logic       rsp_ready,
  input  wire rsp_word_t  rsp,
  output int              fail_count,
  output int              outstanding
);

  bit [31:0] trie_copy [TABLE_WORDS];
  rsp_word_t answers_due [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] lookup mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic rsp_word_t trie_walk(input logic [31:0] ip);
    rsp_word_t res;
    longint unsigned offset;
    longint unsigned index;
    logic [31:0] entry;
    res.status = ST_BROKEN;
    res.country_code = 16'h0000;
    offset = 0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if ((offset & 3) != 0) begin
        return res;
      end
      index = (offset >> 2) + ip[31 - 8*lvl -: 8];
      if (index >= TABLE_WORDS) begin
        return res;
      end
      entry = trie_copy[index];
      if (entry[31:16] == LEAF_MARK) begin
        if (entry[15:0] == 16'h0000) begin
          res.status = ST_MISSING;
        end else begin
          res.status = ST_FOUND;
          res.country_code = entry[15:0];
        end
        return res;
      end
      offset = entry;
    end
    return res;
  endfunction

  // Results are checked before the request of the same edge is taken in.
  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      answers_due.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result with none pending: status %0d code %h",
                                    rsp.status, rsp.country_code));
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
          end
          if (rsp.country_code !== want.country_code) begin
            report_mismatch($sformatf("country code %h, wanted %h",
                                      rsp.country_code, want.country_code));
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.opcode == OP_WRITE) begin
          trie_copy[req.word_address] = req.write_word;
        end else begin
          answers_due.push_back(trie_walk(req.ip_address));
        end
      end
      outstanding <= answers_due.size();
    end
  end

endmodule

[verif/testbench.sv]
module testbench;
  import itcl_pkg::*;

  localparam int TABLE_WORDS = 65536;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_SLOW} sink_mode_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;
  int        fail_count;
  int        outstanding;

  logic [31:0] plan_mem [int];
  int unsigned trie_bases [$];
  int          items_sent = 0;
  int          burst_left = 0;
  sink_mode_t  sink_mode = SINK_OPEN;
  int          sink_left = 0;

  ipv4_trie_country_lookup #(.TABLE_WORDS(TABLE_WORDS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lookup_checker #(.TABLE_WORDS(TABLE_WORDS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(8, 80);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN:   rsp_ready <= 1'b1;
      SINK_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
      default:     rsp_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Returns the first table entry that a lookup of ip would read before it has been
  // written, or -1 when the walk touches only written entries.
  function automatic int first_unwritten(input logic [31:0] ip);
    longint unsigned offset;
    longint unsigned index;
    logic [31:0] entry;
    offset = 0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if ((offset & 3) != 0) begin
        return -1;
      end
      index = (offset >> 2) + ip[31 - 8*lvl -: 8];
      if (index >= TABLE_WORDS) begin
        return -1;
      end
      if (!plan_mem.exists(int'(index))) begin
        return int'(index);
      end
      entry = plan_mem[int'(index)];
      if (entry[31:16] == LEAF_MARK) begin
        return -1;
      end
      offset = entry;
    end
    return -1;
  endfunction

  task automatic send_word(input req_word_t w);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (w.opcode == OP_WRITE) begin
      plan_mem[int'(w.word_address)] = w.write_word;
    end
    req <= w;
    req_valid <= 1'b1;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [31:0] data);
    req_word_t w;
    w.opcode = OP_WRITE;
    w.word_address = addr;
    w.write_word = data;
    w.ip_address = $urandom;
    send_word(w);
  endtask

  task automatic send_lookup(input logic [31:0] ip);
    req_word_t w;
    w.opcode = OP_LOOKUP;
    w.word_address = 16'($urandom);
    w.write_word = $urandom;
    w.ip_address = ip;
    send_word(w);
  endtask

  initial begin
    logic [31:0] ip;
    logic [31:0] fill;
    int hole;
    int unsigned roll;
    int unsigned base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    trie_bases.push_back(0);
    trie_bases.push_back(256);
    trie_bases.push_back(512);

    send_write(16'd10, {LEAF_MARK, 16'h4445});
    send_lookup({8'd10, 24'($urandom)});
    send_write(16'd11, {LEAF_MARK, 16'h0000});
    send_lookup({8'd11, 24'($urandom)});
    send_write(16'd12, 32'h0000_0400);
    send_write(16'd261, {LEAF_MARK, 16'h5553});
    send_lookup({8'd12, 8'd5, 16'($urandom)});
    send_write(16'd13, 32'h0000_0401);
    send_lookup({8'd13, 24'($urandom)});
    send_write(16'd14, 32'h0003_FFFC);
    send_lookup({8'd14, 8'd1, 16'($urandom)});
    send_write(16'hFFFF, 32'hFFFF_FFFF);
    send_lookup({8'd14, 8'd0, 16'($urandom)});
    send_write(16'd15, 32'h0000_0800);
    send_write(16'd512, 32'h0000_0800);
    send_lookup({8'd15, 24'h000000});
    send_write(16'd0, 32'h0000_0000);
    send_lookup(32'h0000_0000);
    send_write(16'd16, 32'hFFFE_0000);
    send_lookup({8'd16, 24'($urandom)});
    send_write(16'd255, {LEAF_MARK, 16'h0001});
    send_lookup(32'hFFFF_FFFF);

    // Let the block drain completely before the random part begins.
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    while (items_sent < 420) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_write(16'($urandom), $urandom);
      end else begin
        ip = $urandom;
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 9) < 7) begin
            ip[8*k +: 8] = 8'($urandom_range(0, 7));
          end
        end
        // Every entry on the path is written before the lookup, so that the trie grows
        // along the addresses actually used.
        hole = first_unwritten(ip);
        while (hole >= 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 35) begin
            fill = {LEAF_MARK, 16'($urandom_range(1, 65535))};
          end else if (roll < 45) begin
            fill = {LEAF_MARK, 16'h0000};
          end else if (roll < 85) begin
            if ($urandom_range(0, 3) == 0) begin
              base = trie_bases[$urandom_range(0, trie_bases.size() - 1)];
            end else begin
              base = $urandom_range(0, 65535 - 255);
              trie_bases.push_back(base);
            end
            fill = 32'(base) << 2;
          end else if (roll < 90) begin
            fill = (32'($urandom_range(0, 65535)) << 2) | 32'($urandom_range(1, 3));
          end else if (roll < 95) begin
            fill = 32'($urandom_range(65281, 65535)) << 2;
          end else begin
            fill = $urandom;
          end
          send_write(hole[15:0], fill);
          hole = first_unwritten(ip);
        end
        send_lookup(ip);
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
